// ===== rtl/emlbc_pkg.sv =====
package emlbc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_DEPTH = 1024;
  localparam int NDIR      = 6;
  localparam int NPOP      = 2 * NDIR;
  localparam int NCOMP     = 3;

  localparam int POP_W   = 32;
  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 11;
  localparam int Z_W     = 10;
  localparam int DIR_W   = 3;
  localparam int IDX_W   = 2;
  localparam int KW      = 31;
  localparam int PC_W    = 5;
  localparam int SLOT_W  = 4;
  localparam int COMP_W  = 2;

  // Sum of six 32-bit values, and the magnitude of one cross component.
  localparam int SUM_W   = POP_W + 3;
  localparam int MAG_W   = SUM_W - 1;
  localparam int HI_W    = MAG_W - FRAC_BITS;
  localparam int MUL_A_W = FRAC_BITS;
  localparam int PROD_W  = MUL_A_W + KW;
  localparam int HIP_W   = HI_W + KW;
  localparam int R_W     = HIP_W + 1;
  localparam int TRI_W   = R_W + 2;
  localparam int T_W     = TRI_W + 2;
  localparam int Q_W     = TRI_W;
  localparam int FEQ_W   = Q_W + 1;
  localparam int FIN_W   = FEQ_W + 2;

  // Divide-by-six unit: four radix-16 digits per cycle.
  localparam int DIV_DIGITS = 4;
  localparam int DIV_BITS   = 4 * DIV_DIGITS;
  localparam int DIV_CYCLES = 3;
  localparam int DV_W       = DIV_BITS * DIV_CYCLES;

  localparam logic [IDX_W-1:0] REG_LATTICE_DEPTH = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_INV_EPS_LOW   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_INV_EPS_HIGH  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_INV_MU        = IDX_W'(3);

  localparam logic [DEPTH_W-1:0] DEPTH_RST    = DEPTH_W'(100);
  localparam logic [KW-1:0]      INV_EPS_LO_RST = KW'(5592405);
  localparam logic [KW-1:0]      INV_EPS_HI_RST = KW'(2236962);
  localparam logic [KW-1:0]      INV_MU_RST     = KW'(5592405);

  typedef enum logic [3:0] {
    OP_WAIT, OP_SRD, OP_SACC, OP_ORD, OP_SEL, OP_MH, OP_ML, OP_ADD,
    OP_TRI, OP_TSUM, OP_ABS, OP_DIV, OP_NEGQ, OP_FIN, OP_EMIT, OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT, COND_ALWAYS, COND_NOT_FULL, COND_SLOT_MORE, COND_COMP_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic              zero;
    logic [COMP_W-1:0] src;
    logic              flip;
  } xsel_t;

  localparam logic [PC_W-1:0] PC_WAIT   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SUM_RD = PC_W'(1);
  localparam logic [PC_W-1:0] PC_OUT_RD = PC_W'(3);
  localparam logic [PC_W-1:0] PC_SEL    = PC_W'(4);

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_W'(0):  w = '{OP_WAIT, COND_NOT_FULL,  PC_WAIT};
      PC_W'(1):  w = '{OP_SRD,  COND_NEXT,      PC_WAIT};
      PC_W'(2):  w = '{OP_SACC, COND_SLOT_MORE, PC_SUM_RD};
      PC_W'(3):  w = '{OP_ORD,  COND_NEXT,      PC_WAIT};
      PC_W'(4):  w = '{OP_SEL,  COND_NEXT,      PC_WAIT};
      PC_W'(5):  w = '{OP_MH,   COND_NEXT,      PC_WAIT};
      PC_W'(6):  w = '{OP_ML,   COND_NEXT,      PC_WAIT};
      PC_W'(7):  w = '{OP_ADD,  COND_NEXT,      PC_WAIT};
      PC_W'(8):  w = '{OP_TRI,  COND_NEXT,      PC_WAIT};
      PC_W'(9):  w = '{OP_TSUM, COND_NEXT,      PC_WAIT};
      PC_W'(10): w = '{OP_ABS,  COND_NEXT,      PC_WAIT};
      PC_W'(11): w = '{OP_DIV,  COND_NEXT,      PC_WAIT};
      PC_W'(12): w = '{OP_DIV,  COND_NEXT,      PC_WAIT};
      PC_W'(13): w = '{OP_DIV,  COND_NEXT,      PC_WAIT};
      PC_W'(14): w = '{OP_NEGQ, COND_NEXT,      PC_WAIT};
      PC_W'(15): w = '{OP_FIN,  COND_COMP_MORE, PC_SEL};
      PC_W'(16): w = '{OP_EMIT, COND_SLOT_MORE, PC_OUT_RD};
      default:   w = '{OP_NOP,  COND_ALWAYS,    PC_WAIT};
    endcase
    return w;
  endfunction

  // One radix-16 digit of an unsigned divide by six. Returns {quotient, remainder}.
  // floor(v*43/256) equals floor(v/6) for all v below 96.
  function automatic logic [6:0] div6_digit(input logic [2:0] rem, input logic [3:0] nib);
    logic [6:0]  v;
    logic [11:0] p;
    logic [3:0]  q;
    logic [6:0]  q6;
    v  = {rem, nib};
    p  = 12'(v) * 12'd43;
    q  = p[11:8];
    q6 = 7'({q, 2'b00}) + 7'({q, 1'b0});
    return {q, 3'(v - q6)};
  endfunction

  // Cross product of a direction's unit vector with a field vector:
  // which component feeds output component comp, and with which sign.
  function automatic xsel_t cross_sel(input logic [DIR_W-1:0] dir,
                                      input logic [COMP_W-1:0] comp);
    xsel_t             s;
    logic              sneg;
    logic [COMP_W-1:0] axis;
    logic [COMP_W-1:0] next_axis;
    sneg      = (dir == DIR_W'(2)) || (dir == DIR_W'(3)) || (dir == DIR_W'(4));
    axis      = ((dir == DIR_W'(0)) || (dir == DIR_W'(2))) ? COMP_W'(0) :
                ((dir == DIR_W'(1)) || (dir == DIR_W'(3))) ? COMP_W'(1) : COMP_W'(2);
    next_axis = (axis == COMP_W'(2)) ? COMP_W'(0) : axis + COMP_W'(1);
    s.zero    = (comp == axis);
    s.src     = COMP_W'(3) - axis - comp;
    s.flip    = (comp == next_axis) ? ~sneg : sneg;
    return s;
  endfunction

endpackage

// ===== rtl/em_lattice_boltzmann_collision_top.sv =====
// BGK collision for one D3Q6 electromagnetic lattice cell. Populations are
// taken one per cycle until twelve have arrived; a transfer with direction 6
// or 7 is consumed and dropped. The twelfth transfer starts the collision:
// a microcoded sequencer sums the stored sets, then for each of the twelve
// results runs three components through one 24x31 multiplier and a
// divide-by-six unit, 12 steps per component. Back-pressure on the output
// holds the sequencer at the emit step. The input is closed during the
// collision; the last result may still sit in the output register while
// the next cell loads. Config writes are taken on any cycle and must only
// occur while the block is idle.
module em_lattice_boltzmann_collision_top import emlbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [Z_W-1:0]          z_index_i,
  input  logic                    field_set_i,
  input  logic [DIR_W-1:0]        direction_i,
  input  logic signed [POP_W-1:0] pop_x_i,
  input  logic signed [POP_W-1:0] pop_y_i,
  input  logic signed [POP_W-1:0] pop_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_field_set_o,
  output logic [DIR_W-1:0]        out_direction_o,
  output logic signed [POP_W-1:0] out_x_o,
  output logic signed [POP_W-1:0] out_y_o,
  output logic signed [POP_W-1:0] out_z_o,
  output logic                    last_of_cell_o
);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NPOP - 1);
  localparam logic [SLOT_W-1:0] SLOT_SET1 = SLOT_W'(NDIR);
  localparam logic [COMP_W-1:0] COMP_LAST = COMP_W'(NCOMP - 1);

  function automatic logic signed [POP_W-1:0] pick(input logic [3*POP_W-1:0] v,
                                                   input logic [COMP_W-1:0] c);
    logic signed [POP_W-1:0] r;
    unique case (c)
      COMP_W'(0): r = v[POP_W-1:0];
      COMP_W'(1): r = v[2*POP_W-1:POP_W];
      default:    r = v[3*POP_W-1:2*POP_W];
    endcase
    return r;
  endfunction

  function automatic logic [POP_W-1:0] sat32(input logic signed [FIN_W-1:0] v);
    logic [POP_W-1:0] r;
    if (v[FIN_W-1:POP_W-1] == '0 || v[FIN_W-1:POP_W-1] == '1) begin
      r = v[POP_W-1:0];
    end else begin
      r = {v[FIN_W-1], {(POP_W-1){~v[FIN_W-1]}}};
    end
    return r;
  endfunction

  // Sequencer
  uword_t          uw;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            cond_hit, hold;

  // Load side
  logic              in_acc, dir_ok, full_hit;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] count_q, slot_q, slot_nxt;
  logic [COMP_W-1:0] comp_q;
  logic [Z_W-1:0]    cell_z_q;

  // Configuration
  logic [DEPTH_W-1:0] depth_q, depth_wr;
  logic [KW-1:0]      inv_eps_lo_q, inv_eps_hi_q, inv_mu_q;

  // Store
  logic [3*POP_W-1:0] mem [NPOP];
  logic [3*POP_W-1:0] rd_q;

  // Datapath
  logic signed [SUM_W-1:0] sum_q [2][NCOMP];
  logic                    rset;
  logic [DIR_W-1:0]        slot_dir;
  xsel_t                   xs;
  logic signed [SUM_W-1:0] xv, xv_abs;
  logic [KW-1:0]           k_q, k_sel;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q, sub_q, tneg_q;
  logic [MUL_A_W-1:0]      mul_a;
  logic [PROD_W-1:0]       prod, prod_q;
  logic [HIP_W-1:0]        hip_q;
  logic [R_W-1:0]          r_q;
  logic [TRI_W-1:0]        tri_q;
  logic signed [T_W-1:0]   t_q, t_abs, sum_ext, tri_ext;
  logic [DV_W-1:0]         dv_q;
  logic [2:0]              rem_q, rem_nxt;
  logic [DIV_BITS-1:0]     qbits;
  logic [6:0]              dig;
  logic signed [FEQ_W-1:0] feq_q;
  logic signed [FIN_W-1:0] fin_v;
  logic [POP_W-1:0]        res_q [NCOMP];
  logic                    out_free, emit;

  assign uw          = ucode(pc_q);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (uw.op == OP_WAIT);
  assign in_acc      = in_valid_i & in_ready_o;
  assign dir_ok      = (direction_i < DIR_W'(NDIR));
  assign full_hit    = in_acc & dir_ok & (count_q == SLOT_LAST);
  assign wr_slot     = (field_set_i ? SLOT_SET1 : SLOT_W'(0)) + SLOT_W'(direction_i);
  assign slot_nxt    = (slot_q == SLOT_LAST) ? SLOT_W'(0) : slot_q + SLOT_W'(1);
  assign rset        = (slot_q >= SLOT_SET1);
  assign slot_dir    = rset ? DIR_W'(slot_q - SLOT_SET1) : DIR_W'(slot_q);
  assign out_free    = ~out_valid_o | out_ready_i;
  assign emit        = (uw.op == OP_EMIT) & out_free;

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_NOT_FULL:  cond_hit = ~full_hit;
      COND_SLOT_MORE: cond_hit = (slot_q != SLOT_LAST);
      COND_COMP_MORE: cond_hit = (comp_q != COMP_LAST);
      default:        cond_hit = 1'b0;
    endcase
    hold = (uw.op == OP_EMIT) & ~out_free;
    if (hold) begin
      pc_d = pc_q;
    end else if (cond_hit) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  // Depth writes above the lattice limit clamp to it.
  always_comb begin
    depth_wr = cfg_data_i[DEPTH_W-1:0];
    if (depth_wr > DEPTH_W'(MAX_DEPTH)) begin
      depth_wr = DEPTH_W'(MAX_DEPTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= PC_WAIT;
      count_q      <= '0;
      slot_q       <= '0;
      comp_q       <= '0;
      cell_z_q     <= '0;
      out_valid_o  <= 1'b0;
      depth_q      <= DEPTH_RST;
      inv_eps_lo_q <= INV_EPS_LO_RST;
      inv_eps_hi_q <= INV_EPS_HI_RST;
      inv_mu_q     <= INV_MU_RST;
    end else begin
      pc_q <= pc_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_LATTICE_DEPTH: depth_q      <= depth_wr;
          REG_INV_EPS_LOW:   inv_eps_lo_q <= cfg_data_i[KW-1:0];
          REG_INV_EPS_HIGH:  inv_eps_hi_q <= cfg_data_i[KW-1:0];
          REG_INV_MU:        inv_mu_q     <= cfg_data_i[KW-1:0];
          default: ;
        endcase
      end
      if (in_acc && dir_ok) begin
        count_q <= (count_q == SLOT_LAST) ? SLOT_W'(0) : count_q + SLOT_W'(1);
        if (count_q == '0) begin
          cell_z_q <= z_index_i;
        end
      end
      if (uw.op == OP_SACC || emit) begin
        slot_q <= slot_nxt;
      end
      if (uw.op == OP_ORD) begin
        comp_q <= '0;
      end else if (uw.op == OP_FIN) begin
        comp_q <= (comp_q == COMP_LAST) ? COMP_W'(0) : comp_q + COMP_W'(1);
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Population store
  always_ff @(posedge clk_i) begin
    if (in_acc && dir_ok) begin
      mem[wr_slot] <= {pop_z_i, pop_y_i, pop_x_i};
    end
    if (uw.op == OP_SRD || uw.op == OP_ORD) begin
      rd_q <= mem[slot_q];
    end
  end

  // Combinational pieces of the datapath
  assign k_sel = ({1'b0, cell_z_q} > (depth_q >> 1)) ? inv_eps_hi_q : inv_eps_lo_q;
  assign xs    = cross_sel(slot_dir, comp_q);
  assign xv    = sum_q[~rset][xs.src];
  assign xv_abs = xv[SUM_W-1] ? -xv : xv;
  assign mul_a = (uw.op == OP_MH) ? MUL_A_W'(mag_q[MAG_W-1:FRAC_BITS])
                                  : mag_q[FRAC_BITS-1:0];
  assign prod  = PROD_W'(mul_a) * PROD_W'(k_q);
  assign sum_ext = T_W'(sum_q[rset][comp_q]);
  assign tri_ext = $signed({2'b00, tri_q});
  assign t_abs = t_q[T_W-1] ? -t_q : t_q;
  assign fin_v = FIN_W'($signed({feq_q, 1'b0})) - FIN_W'(pick(rd_q, comp_q));

  always_comb begin
    rem_nxt = rem_q;
    qbits   = '0;
    dig     = '0;
    for (int n = 0; n < DIV_DIGITS; n++) begin
      dig = div6_digit(rem_nxt, dv_q[DV_W-1-4*n -: 4]);
      qbits[DIV_BITS-1-4*n -: 4] = dig[6:3];
      rem_nxt = dig[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_WAIT: begin
        for (int s = 0; s < 2; s++) begin
          for (int c = 0; c < NCOMP; c++) begin
            sum_q[s][c] <= '0;
          end
        end
      end
      OP_SACC: begin
        for (int c = 0; c < NCOMP; c++) begin
          sum_q[rset][c] <= sum_q[rset][c] + SUM_W'(pick(rd_q, COMP_W'(c)));
        end
      end
      OP_ORD: k_q <= rset ? k_sel : inv_mu_q;
      OP_SEL: begin
        mag_q <= xs.zero ? '0 : $unsigned(xv_abs[MAG_W-1:0]);
        neg_q <= xv[SUM_W-1] ^ xs.flip;
      end
      OP_MH:  prod_q <= prod;
      OP_ML: begin
        hip_q  <= prod_q[HIP_W-1:0];
        prod_q <= prod;
      end
      OP_ADD: r_q <= R_W'(hip_q) + R_W'(prod_q[PROD_W-1:FRAC_BITS]);
      OP_TRI: begin
        // Set 0 subtracts the cross term, set 1 adds it.
        tri_q <= TRI_W'({r_q, 1'b0}) + TRI_W'(r_q);
        sub_q <= neg_q ^ ~rset;
      end
      OP_TSUM: t_q <= sub_q ? sum_ext - tri_ext : sum_ext + tri_ext;
      OP_ABS: begin
        tneg_q <= t_q[T_W-1];
        dv_q   <= DV_W'($unsigned(t_abs));
        rem_q  <= '0;
      end
      OP_DIV: begin
        dv_q  <= {dv_q[DV_W-DIV_BITS-1:0], qbits};
        rem_q <= rem_nxt;
      end
      OP_NEGQ: feq_q <= tneg_q ? -$signed({1'b0, dv_q[Q_W-1:0]})
                               : $signed({1'b0, dv_q[Q_W-1:0]});
      OP_FIN: res_q[comp_q] <= sat32(fin_v);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_field_set_o <= rset;
      out_direction_o <= slot_dir;
      out_x_o         <= res_q[0];
      out_y_o         <= res_q[1];
      out_z_o         <= res_q[2];
      last_of_cell_o  <= (slot_q == SLOT_LAST);
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import emlbc_pkg::*;

  localparam int   LIMIT_CYCLES  = 400000;
  localparam int   SETTLE_CYCLES = 40;
  localparam logic SET_D         = 1'b0;
  localparam logic SET_B         = 1'b1;

  typedef struct packed {
    logic              fset;
    logic [DIR_W-1:0]  dir;
    logic [POP_W-1:0]  x;
    logic [POP_W-1:0]  y;
    logic [POP_W-1:0]  z;
    logic              last;
  } post_pop_t;

  class bgk_scoreboard;
    longint          slot_val[NPOP][NCOMP];
    int unsigned     loaded;
    int unsigned     cell_z;
    int unsigned     depth;
    longint unsigned k_eps_low;
    longint unsigned k_eps_high;
    longint unsigned k_mu;
    post_pop_t       awaited[$];
    int unsigned     errors;

    function new();
      foreach (slot_val[i, j]) slot_val[i][j] = 0;
      loaded     = 0;
      cell_z     = 0;
      depth      = 100;
      k_eps_low  = 5592405;
      k_eps_high = 2236962;
      k_mu       = 5592405;
      errors     = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_LATTICE_DEPTH: depth = (data[DEPTH_W-1:0] > MAX_DEPTH) ? MAX_DEPTH
                                                                  : data[DEPTH_W-1:0];
        REG_INV_EPS_LOW:   k_eps_low  = data[KW-1:0];
        REG_INV_EPS_HIGH:  k_eps_high = data[KW-1:0];
        REG_INV_MU:        k_mu       = data[KW-1:0];
        default: ;
      endcase
    endfunction

    // Q7.24 product on the magnitude, truncated toward zero.
    static function longint scale_q(longint a, longint unsigned k);
      bit              neg;
      longint unsigned m;
      longint unsigned r;
      neg = a < 0;
      m   = neg ? -a : a;
      r   = (m >> FRAC_BITS) * k + (((m & ((64'd1 << FRAC_BITS) - 1)) * k) >> FRAC_BITS);
      return neg ? -longint'(r) : longint'(r);
    endfunction

    // Component comp of (unit vector of dir) x a.
    static function longint cross_comp(int unsigned dir, int unsigned comp,
                                       longint ax, longint ay, longint az);
      longint      s;
      longint      a[NCOMP];
      int unsigned axis;
      a[0] = ax;
      a[1] = ay;
      a[2] = az;
      s    = (dir == 2 || dir == 3 || dir == 4) ? -1 : 1;
      axis = (dir == 0 || dir == 2) ? 0 : (dir == 1 || dir == 3) ? 1 : 2;
      if (comp == axis) return 0;
      if (comp == (axis + 1) % 3) return -s * a[(axis + 2) % 3];
      return s * a[(axis + 1) % 3];
    endfunction

    static function logic [POP_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[POP_W-1:0];
    endfunction

    function void take_population(logic [Z_W-1:0] zi, logic fset, logic [DIR_W-1:0] dir,
                                  logic [POP_W-1:0] px, logic [POP_W-1:0] py,
                                  logic [POP_W-1:0] pz);
      int unsigned      slot;
      longint           sum[2][NCOMP];
      longint unsigned  k_eps;
      longint           t;
      logic [POP_W-1:0] comp_out[NCOMP];
      post_pop_t        res;
      int               n;
      if (dir >= NDIR) return;
      if (loaded == 0) cell_z = zi;
      slot = fset * NDIR + dir;
      slot_val[slot][0] = longint'($signed(px));
      slot_val[slot][1] = longint'($signed(py));
      slot_val[slot][2] = longint'($signed(pz));
      loaded++;
      if (loaded < NPOP) return;
      loaded = 0;
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < NCOMP; c++) begin
          sum[r][c] = 0;
          for (int i = 0; i < NDIR; i++) sum[r][c] += slot_val[r * NDIR + i][c];
        end
      k_eps = (cell_z > (depth >> 1)) ? k_eps_high : k_eps_low;
      n = 0;
      for (int r = 0; r < 2; r++)
        for (int i = 0; i < NDIR; i++) begin
          for (int c = 0; c < NCOMP; c++) begin
            t = cross_comp(i, c, sum[r ^ 1][0], sum[r ^ 1][1], sum[r ^ 1][2]);
            if (r == 0) t = sum[0][c] - 3 * scale_q(t, k_mu);
            else        t = sum[1][c] + 3 * scale_q(t, k_eps);
            comp_out[c] = clamp32(2 * (t / 6) - slot_val[r * NDIR + i][c]);
          end
          res.fset = r[0];
          res.dir  = DIR_W'(i);
          res.x    = comp_out[0];
          res.y    = comp_out[1];
          res.z    = comp_out[2];
          res.last = (n == NPOP - 1);
          n++;
          awaited.push_back(res);
        end
    endfunction

    function void compare(string name, logic signed [63:0] want_v, logic signed [63:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, actual %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(post_pop_t got);
      post_pop_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing pending: set %0d dir %0d", got.fset, got.dir);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("out_field_set", {63'd0, want.fset}, {63'd0, got.fset});
      compare("out_direction", {61'd0, want.dir}, {61'd0, got.dir});
      compare("out_x", $signed(want.x), $signed(got.x));
      compare("out_y", $signed(want.y), $signed(got.y));
      compare("out_z", $signed(want.z), $signed(got.z));
      compare("last_of_cell", {63'd0, want.last}, {63'd0, got.last});
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [IDX_W-1:0]        cfg_index_i;
  logic [DATA_W-1:0]       cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [Z_W-1:0]          z_index_i;
  logic                    field_set_i;
  logic [DIR_W-1:0]        direction_i;
  logic signed [POP_W-1:0] pop_x_i;
  logic signed [POP_W-1:0] pop_y_i;
  logic signed [POP_W-1:0] pop_z_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    out_field_set_o;
  logic [DIR_W-1:0]        out_direction_o;
  logic signed [POP_W-1:0] out_x_o;
  logic signed [POP_W-1:0] out_y_o;
  logic signed [POP_W-1:0] out_z_o;
  logic                    last_of_cell_o;

  bgk_scoreboard sb = new();
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   cycle_count;
  post_pop_t     seen;

  em_lattice_boltzmann_collision_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      seen.fset = out_field_set_o;
      seen.dir  = out_direction_o;
      seen.x    = out_x_o;
      seen.y    = out_y_o;
      seen.z    = out_z_o;
      seen.last = last_of_cell_o;
      sb.check_result(seen);
    end
  end

  // Leaves valid high after the transfer; the next call replaces or drops it, and a drain drops it.
  task automatic send_pop(logic [Z_W-1:0] zi, logic fset, logic [DIR_W-1:0] dir,
                          logic [POP_W-1:0] px, logic [POP_W-1:0] py,
                          logic [POP_W-1:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    z_index_i   <= zi;
    field_set_i <= fset;
    direction_i <= dir;
    pop_x_i     <= px;
    pop_y_i     <= py;
    pop_z_i     <= pz;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.take_population(zi, fset, dir, px, py, pz);
  endtask

  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [DATA_W-1:0] d, logic [DATA_W-1:0] lo,
                           logic [DATA_W-1:0] hi, logic [DATA_W-1:0] mu);
    write_cfg(REG_LATTICE_DEPTH, d);
    write_cfg(REG_INV_EPS_LOW, lo);
    write_cfg(REG_INV_EPS_HIGH, hi);
    write_cfg(REG_INV_MU, mu);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [POP_W-1:0] rand_comp(int unsigned shift);
    logic signed [POP_W-1:0] v;
    v = $urandom;
    return v >>> shift;
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    return $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0400_0000);
  endfunction

  function automatic logic [POP_W-1:0] edge_val(int k);
    case (k % 7)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h0100_0000;
      default: return 32'hFF00_0000;
    endcase
  endfunction

  task automatic random_cell();
    int unsigned      order[NPOP];
    int unsigned      j;
    int unsigned      tmp;
    int unsigned      shift;
    int unsigned      slot;
    int unsigned      half;
    bit               shuffled;
    logic [Z_W-1:0]   z_first;
    for (int i = 0; i < NPOP; i++) order[i] = i;
    for (int i = NPOP - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    shuffled = $urandom_range(9) < 7;
    shift    = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 4);
    half     = sb.depth >> 1;
    case ($urandom_range(3))
      0:       z_first = Z_W'(half);
      1:       z_first = Z_W'(half + 1);
      default: z_first = Z_W'($urandom_range(1023));
    endcase
    for (int k = 0; k < NPOP; k++) begin
      // stray transfer with an invalid direction
      if ($urandom_range(99) < 8)
        send_pop(Z_W'($urandom_range(1023)), 1'($urandom_range(1)),
                 DIR_W'($urandom_range(7, NDIR)), $urandom, $urandom, $urandom);
      slot = shuffled ? order[k] : $urandom_range(NPOP - 1);
      send_pop((k == 0) ? z_first : Z_W'($urandom_range(1023)), 1'(slot / NDIR),
               DIR_W'(slot % NDIR), rand_comp(shift), rand_comp(shift), rand_comp(shift));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    z_index_i   <= '0;
    field_set_i <= 1'b0;
    direction_i <= '0;
    pop_x_i     <= '0;
    pop_y_i     <= '0;
    pop_z_i     <= '0;
    out_ready_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every slot written once, extreme values, two invalid directions
    for (int s = 0; s < NPOP; s++) begin
      if (s == 4) send_pop(10'd0, SET_B, DIR_W'(NDIR), $urandom, $urandom, $urandom);
      if (s == 9) send_pop(10'd1023, SET_D, DIR_W'(NDIR + 1), $urandom, $urandom, $urandom);
      send_pop(10'd0, 1'(s / NDIR), DIR_W'(s % NDIR),
               edge_val(3 * s), edge_val(3 * s + 1), edge_val(3 * s + 2));
    end
    // upper region, saturating sums; slot 0 twice, slot 5 keeps its old value
    send_pop(10'd1023, SET_D, DIR_W'(0), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int s = NPOP - 1; s > 0; s--) begin
      if (s != 5)
        send_pop(10'd0, 1'(s / NDIR), DIR_W'(s % NDIR),
                 (s < NDIR) ? 32'h7FFF_FFFF : 32'h8000_0000,
                 (s < NDIR) ? 32'h7FFF_FFFF : 32'h8000_0000,
                 (s < NDIR) ? 32'h7FFF_FFFF : 32'h8000_0000);
    end
    send_pop(10'd5, SET_D, DIR_W'(0), 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    repeat (2) random_cell();

    for (int p = 1; p <= 8; p++) begin
      drain_results();
      case (p)
        1:       configure(32'd2, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        2:       configure(32'd2047, 32'hFFFF_FFFF, 32'd0, 32'd0);
        3:       configure(32'd1024, rand_gain(), rand_gain(), rand_gain());
        default: configure($urandom_range(1024, 2), rand_gain(), rand_gain(), rand_gain());
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      repeat (4) begin
        random_cell();
        if ($urandom_range(7) == 0) drain_results();
      end
    end

    drain_results();
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/emlbc_pkg.sv
rtl/em_lattice_boltzmann_collision_top.sv
tb/tb.sv
